// ----- rtl/core/pls_pkg.sv -----
// Package: shared types and constants of the positional list store.
`timescale 1ns / 1ps
package pls_pkg;

	localparam int VAL_W      = 32;
	localparam int POS_W      = 7;
	localparam int REQ_W      = 3;
	localparam int STAT_W     = 2;
	localparam int LEN_W      = 7;
	localparam int CNT_MAX_W  = 11;
	localparam int CAPACITY_D = 64;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 48;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ      = 3'd0,
		REQ_INSERT_AT = 3'd1,
		REQ_INSERT_HD = 3'd2,
		REQ_INSERT_TL = 3'd3,
		REQ_DELETE    = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                 ins;
		logic                 del;
		logic [CNT_MAX_W-1:0] pos;
		logic [VAL_W-1:0]     value;
	} cell_ctl_t;

endpackage

// ----- rtl/core/pls_cell.sv -----
// One list entry: hold, load, or take a neighbor's value on insert or delete.
`timescale 1ns / 1ps
module pls_cell #(
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  pls_pkg::cell_ctl_t        ctl,
	input  logic [pls_pkg::VAL_W-1:0] left_d,
	input  logic [pls_pkg::VAL_W-1:0] right_d,
	output logic [pls_pkg::VAL_W-1:0] data_q
);

	localparam logic [pls_pkg::CNT_MAX_W-1:0] MY_IDX = pls_pkg::CNT_MAX_W'(INDEX);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX > ctl.pos) begin
				data_q <= left_d;
			end else if (MY_IDX == ctl.pos) begin
				data_q <= ctl.value;
			end
		end else if (ctl.del) begin
			if (MY_IDX >= ctl.pos) begin
				data_q <= right_d;
			end
		end
	end

endmodule

// ----- rtl/core/positional_list_store.sv -----
// Top level: ordered list of signed values held in a chain of entry cells.
//
// Usage: one request enters on the s_ channel (request kind, position, value)
// and gives exactly one result on the m_ channel (status, value read, new
// length). A request is decoded against the entry count and, in the same
// cycle, every cell either holds, loads the new value, or takes its
// neighbor's value, so an insert or delete moves the whole tail at once.
// The result is registered on acceptance. Throughput is one request per
// cycle while the receiver takes results; the read path is one multiplexer
// over the cells and the count update is a single add or subtract.
// s_tready stays high while the output register is empty or being taken,
// so a stalled receiver holds the result and blocks only the next request.
// Reset clears the entry count and the output valid flag; cell contents
// are left as they are and are never read before being written.
// In-range inserts into a full list report a full status; out-of-range
// positions and unknown request kinds report a range status and change nothing.
`timescale 1ns / 1ps
module positional_list_store #(
	parameter int CAPACITY = pls_pkg::CAPACITY_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// req_type[2:0], position[9:3], value[41:10], zero fill above
	input  logic [pls_pkg::S_DATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[1:0], read_value[33:2], length[40:34], zero fill above
	output logic [pls_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [pls_pkg::CNT_MAX_W-1:0] CAP_W = pls_pkg::CNT_MAX_W'(CAPACITY);

	logic [pls_pkg::REQ_W-1:0]     req_type;
	logic [pls_pkg::POS_W-1:0]     position;
	logic [pls_pkg::VAL_W-1:0]     value;
	logic                          s_acc;

	logic [CW-1:0]                 cnt_q;
	logic [pls_pkg::CNT_MAX_W-1:0] cnt_w;
	logic [pls_pkg::CNT_MAX_W-1:0] pos_w;
	logic [pls_pkg::CNT_MAX_W-1:0] ins_pos;
	logic [pls_pkg::CNT_MAX_W-1:0] next_cnt_w;
	logic [CW-1:0]                 next_cnt;
	logic                          ins_ok;
	logic                          del_ok;
	logic                          rd_ok;
	pls_pkg::status_t              stat;
	pls_pkg::cell_ctl_t            ctl;

	logic [pls_pkg::VAL_W-1:0]     cell_data [CAPACITY];
	logic [pls_pkg::VAL_W-1:0]     rd_data;

	logic                          out_valid_q;
	pls_pkg::status_t              status_q;
	logic [pls_pkg::VAL_W-1:0]     rd_value_q;
	logic [pls_pkg::LEN_W-1:0]     length_q;

	assign req_type = s_tdata[2:0];
	assign position = s_tdata[9:3];
	assign value    = s_tdata[41:10];

	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	assign cnt_w = pls_pkg::CNT_MAX_W'(cnt_q);
	assign pos_w = pls_pkg::CNT_MAX_W'(position);

	always_comb begin
		ins_ok  = 1'b0;
		del_ok  = 1'b0;
		rd_ok   = 1'b0;
		stat    = pls_pkg::ST_RANGE;
		ins_pos = pos_w;
		unique case (pls_pkg::req_t'(req_type))
			pls_pkg::REQ_READ: begin
				if (pos_w < cnt_w) begin
					rd_ok = 1'b1;
					stat  = pls_pkg::ST_DONE;
				end
			end
			pls_pkg::REQ_INSERT_AT, pls_pkg::REQ_INSERT_HD, pls_pkg::REQ_INSERT_TL: begin
				if (pls_pkg::req_t'(req_type) == pls_pkg::REQ_INSERT_HD) begin
					ins_pos = '0;
				end else if (pls_pkg::req_t'(req_type) == pls_pkg::REQ_INSERT_TL) begin
					ins_pos = cnt_w;
				end
				if (ins_pos > cnt_w) begin
					stat = pls_pkg::ST_RANGE;
				end else if (cnt_w >= CAP_W) begin
					stat = pls_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
					stat   = pls_pkg::ST_DONE;
				end
			end
			pls_pkg::REQ_DELETE: begin
				if (pos_w < cnt_w) begin
					del_ok = 1'b1;
					stat   = pls_pkg::ST_DONE;
				end
			end
			default: begin
				stat = pls_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		next_cnt_w = cnt_w;
		if (ins_ok) begin
			next_cnt_w = cnt_w + 1'b1;
		end else if (del_ok) begin
			next_cnt_w = cnt_w - 1'b1;
		end
	end
	assign next_cnt = next_cnt_w[CW-1:0];

	assign ctl.ins   = s_acc && ins_ok;
	assign ctl.del   = s_acc && del_ok;
	assign ctl.pos   = ins_ok ? ins_pos : pos_w;
	assign ctl.value = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [pls_pkg::VAL_W-1:0] left_d;
		logic [pls_pkg::VAL_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		pls_cell #(
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.left_d (left_d),
			.right_d(right_d),
			.data_q (cell_data[i])
		);
	end

	assign rd_data = rd_ok ? cell_data[pos_w[IW-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				cnt_q       <= next_cnt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			status_q   <= stat;
			rd_value_q <= rd_data;
			length_q   <= next_cnt_w[pls_pkg::LEN_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, length_q, rd_value_q, status_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pls_pkg::CNT_MAX_W'(cnt_q) <= CAP_W)
		else $error("entry count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && ins_ok) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("insert did not advance the count");

	a_full_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == pls_pkg::ST_FULL) |-> (pls_pkg::CNT_MAX_W'(cnt_q) == CAP_W))
		else $error("full status with room left");

endmodule

// ----- bench/pls_checker.sv -----
// Checker: tracks the list from accepted requests and compares every result item.
`timescale 1ns / 1ps
module pls_checker
	import pls_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_D
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  fail_count,
	output int                  pending,
	output int                  list_length,
	output int                  results_seen,
	output int                  done_seen,
	output int                  range_seen,
	output int                  full_seen,
	output int                  peak_length
);

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [VAL_W-1:0] read_value;
		status_t          status;
	} list_result_t;

	logic [VAL_W-1:0] list_vals [CAPACITY];
	int               held;
	list_result_t     expected_q [$];
	int               mismatches;
	int               n_results;
	int               n_done;
	int               n_range;
	int               n_full;
	int               n_peak;

	function automatic status_t place_value(int at, logic [VAL_W-1:0] v);
		if (at > held)
			return ST_RANGE;
		if (held >= CAPACITY)
			return ST_FULL;
		for (int i = held; i > at; i--)
			list_vals[i] = list_vals[i-1];
		list_vals[at] = v;
		held++;
		return ST_DONE;
	endfunction

	function automatic status_t drop_value(int at);
		if (at >= held)
			return ST_RANGE;
		for (int i = at; i + 1 < held; i++)
			list_vals[i] = list_vals[i+1];
		held--;
		return ST_DONE;
	endfunction

	function automatic list_result_t serve_request(logic [S_DATA_W-1:0] item);
		list_result_t     r;
		logic [REQ_W-1:0] kind;
		int               at;
		logic [VAL_W-1:0] v;
		kind = item[REQ_W-1:0];
		at = int'(item[REQ_W +: POS_W]);
		v = item[REQ_W+POS_W +: VAL_W];
		r.read_value = '0;
		r.status = ST_RANGE;
		case (kind)
			REQ_READ: begin
				if (at < held) begin
					r.read_value = list_vals[at];
					r.status = ST_DONE;
				end
			end
			REQ_INSERT_AT: r.status = place_value(at, v);
			REQ_INSERT_HD: r.status = place_value(0, v);
			REQ_INSERT_TL: r.status = place_value(held, v);
			REQ_DELETE:    r.status = drop_value(at);
			default:       r.status = ST_RANGE;
		endcase
		r.length = LEN_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got = list_result_t'(m_tdata[LEN_W+VAL_W+STAT_W-1:0]);
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d: nothing expected, got status %0d value %0d length %0d",
							n_results, got.status, $signed(got.read_value), got.length);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					case (want.status)
						ST_DONE:  n_done++;
						ST_RANGE: n_range++;
						default:  n_full++;
					endcase
					if (got !== want) begin
						if (mismatches < 10)
							$display("result %0d: expected status %0d value %0d length %0d, got status %0d value %0d length %0d",
								n_results, want.status, $signed(want.read_value), want.length,
								got.status, $signed(got.read_value), got.length);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(serve_request(s_tdata));
				if (held > n_peak)
					n_peak = held;
			end
		end
		fail_count <= mismatches;
		pending <= expected_q.size();
		list_length <= held;
		results_seen <= n_results;
		done_seen <= n_done;
		range_seen <= n_range;
		full_seen <= n_full;
		peak_length <= n_peak;
	end

endmodule

// ----- bench/tb_positional_list_store.sv -----
// Testbench top: drives requests into the positional list store and gives the verdict.
`timescale 1ns / 1ps
module tb_positional_list_store;
	import pls_pkg::*;

	localparam int               ITEMS_PER_PHASE = 400;
	localparam int               CYCLE_LIMIT     = 200000;
	localparam int               SETTLE          = 4;
	localparam logic [REQ_W-1:0] REQ_KIND_MAX    = '1;
	localparam logic [POS_W-1:0] POS_TOP         = '1;
	localparam logic [VAL_W-1:0] VAL_MAX         = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN         = {1'b1, {(VAL_W-1){1'b0}}};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int sender_idle_pct = 0;
	int sink_stall_pct  = 0;
	int cycles          = 0;
	int fail_count;
	int pending;
	int list_length;
	int results_seen;
	int done_seen;
	int range_seen;
	int full_seen;
	int peak_length;

	positional_list_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pls_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.list_length  (list_length),
		.results_seen (results_seen),
		.done_seen    (done_seen),
		.range_seen   (range_seen),
		.full_seen    (full_seen),
		.peak_length  (peak_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("positional_list_store: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [S_DATA_W-1:0] pack_request(logic [REQ_W-1:0] kind,
			logic [POS_W-1:0] at, logic [VAL_W-1:0] v);
		return {{(S_DATA_W-REQ_W-POS_W-VAL_W){1'b0}}, v, at, kind};
	endfunction

	function automatic logic [REQ_W-1:0] pick_kind(bit growing);
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return REQ_W'($urandom_range(REQ_KIND_MAX, REQ_DELETE + 1));
		if (growing) begin
			if (roll < 30) return REQ_INSERT_AT;
			if (roll < 55) return REQ_INSERT_HD;
			if (roll < 80) return REQ_INSERT_TL;
			if (roll < 92) return REQ_READ;
			return REQ_DELETE;
		end
		if (roll < 8)  return REQ_INSERT_AT;
		if (roll < 12) return REQ_INSERT_HD;
		if (roll < 16) return REQ_INSERT_TL;
		if (roll < 40) return REQ_READ;
		return REQ_DELETE;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80) return POS_W'($urandom_range(list_length));
		if (roll < 85) return '0;
		if (roll < 90) return POS_W'(list_length);
		if (roll < 93) return POS_W'(CAPACITY_D);
		return POS_W'($urandom_range(POS_TOP));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '1;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	task automatic push_request(input logic [S_DATA_W-1:0] item);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= item;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(pack_request(REQ_READ, '0, '0));
		push_request(pack_request(REQ_DELETE, '0, '0));
		push_request(pack_request(REQ_INSERT_AT, 7'd1, VAL_MAX));
		push_request(pack_request(REQ_INSERT_TL, '0, VAL_MAX));
		push_request(pack_request(REQ_INSERT_HD, '0, VAL_MIN));
		push_request(pack_request(REQ_INSERT_AT, 7'd2, '1));
		push_request(pack_request(REQ_INSERT_AT, 7'd1, '0));
		push_request(pack_request(REQ_INSERT_AT, 7'd5, VAL_MAX));
		for (int i = 0; i < 5; i++)
			push_request(pack_request(REQ_READ, POS_W'(i), '1));
		push_request(pack_request(REQ_READ, POS_TOP, '0));
		push_request(pack_request(REQ_DELETE, POS_TOP, '0));
		push_request(pack_request(REQ_INSERT_AT, POS_TOP, 32'h5A5A_A5A5));
		for (int k = REQ_DELETE + 1; k <= REQ_KIND_MAX; k++)
			push_request(pack_request(REQ_W'(k), '0, '1));
		push_request(pack_request(REQ_DELETE, 7'd1, '0));
		push_request(pack_request(REQ_DELETE, '0, '0));
		push_request(pack_request(REQ_DELETE, 7'd1, '0));
		push_request(pack_request(REQ_READ, '0, '0));
		push_request(pack_request(REQ_INSERT_AT, '0, 32'h1234_5678));
		drain_results();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					sender_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 61;
					sink_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					sink_stall_pct = 61;
				end
				default: begin
					sender_idle_pct = 8;
					sink_stall_pct = 8;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				push_request(pack_request(pick_kind(((n / 100) % 2) == 0), pick_position(),
					pick_value()));
			drain_results();
		end
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests answered: %0d done, %0d out of range, %0d refused as full",
			results_seen, done_seen, range_seen, full_seen);
		$display("list grew to %0d entries under four idle and stall mixes", peak_length);
		if (fail_count == 0 && pending == 0) begin
			$display("positional_list_store: match");
		end else begin
			$display("positional_list_store: mismatch");
		end
		$finish;
	end

endmodule
